### src/rtc_pkg.sv
package rtc_pkg;

	// CORDIC datapath widths: x/y carry 40 fraction bits, z is a 33-bit phase residual
	localparam int XyW = 43;
	localparam int ZW = 33;
	localparam int CordicSteps = 30;

	localparam logic [31:0] DegScale = 32'd3054198966;
	localparam logic [31:0] RadScale = 32'd2734261102;
	localparam logic signed [XyW-1:0] CordicX0 = 43'sd667681663045;
	localparam logic signed [33:0] OneQ30 = 34'sd1073741824;

	typedef struct packed {
		logic [XyW-1:0] x;
		logic [XyW-1:0] y;
		logic [ZW-1:0]  z;
		logic [1:0]     quad;
	} cordic_t;

	// round(atan(2^-i) * 2^31 / pi)
	function automatic logic [29:0] atan_val(input int i);
		logic [29:0] r;
		unique case (i)
			0: r = 30'd536870912;
			1: r = 30'd316933406;
			2: r = 30'd167458907;
			3: r = 30'd85004756;
			4: r = 30'd42667331;
			5: r = 30'd21354465;
			6: r = 30'd10679838;
			7: r = 30'd5340245;
			8: r = 30'd2670163;
			9: r = 30'd1335087;
			10: r = 30'd667544;
			11: r = 30'd333772;
			12: r = 30'd166886;
			13: r = 30'd83443;
			14: r = 30'd41722;
			15: r = 30'd20861;
			16: r = 30'd10430;
			17: r = 30'd5215;
			18: r = 30'd2608;
			19: r = 30'd1304;
			20: r = 30'd652;
			21: r = 30'd326;
			22: r = 30'd163;
			23: r = 30'd81;
			24: r = 30'd41;
			25: r = 30'd20;
			26: r = 30'd10;
			27: r = 30'd5;
			28: r = 30'd3;
			29: r = 30'd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	// saturate to [-1.0, 1.0] in Q1.30
	function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > OneQ30) r = 32'sd1073741824;
		else if (v < -OneQ30) r = -32'sd1073741824;
		else r = v[31:0];
		return r;
	endfunction

	// Q1.30 * Q1.30 product back to Q1.30, half-up rounding
	function automatic logic signed [31:0] rnd_q30(input logic signed [63:0] p);
		logic signed [63:0] s;
		s = p + 64'sd536870912;
		return s[61:30];
	endfunction

endpackage

### src/rtc_cordic_cell.sv
module rtc_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic             clk,
	input  logic             en,
	input  rtc_pkg::cordic_t d,
	output rtc_pkg::cordic_t q_o
);
	import rtc_pkg::*;

	logic signed [XyW-1:0] xi, yi, dx, dy;
	logic signed [ZW-1:0]  zi, at;

	assign xi = $signed(d.x);
	assign yi = $signed(d.y);
	assign zi = $signed(d.z);
	assign dx = yi >>> STEP;
	assign dy = xi >>> STEP;
	assign at = $signed({3'b000, atan_val(STEP)});

	// one micro-rotation, direction from the sign of the residual
	always_ff @(posedge clk) begin
		if (en) begin
			if (!zi[ZW-1]) begin
				q_o.x <= xi - dx;
				q_o.y <= yi + dy;
				q_o.z <= zi - at;
			end else begin
				q_o.x <= xi + dx;
				q_o.y <= yi - dy;
				q_o.z <= zi + at;
			end
			q_o.quad <= d.quad;
		end
	end

endmodule

### src/rtc_angle_front.sv
module rtc_angle_front #(
	parameter int ANGLE_FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] angle,
	input  logic               mode,
	output rtc_pkg::cordic_t   d_o
);
	import rtc_pkg::*;

	localparam int ShDeg = 8 + ANGLE_FRACTION_BITS;
	localparam int ShRad = 2 + ANGLE_FRACTION_BITS;
	localparam logic [63:0] HalfDeg = 64'd1 << (ShDeg - 1);
	localparam logic [63:0] HalfRad = 64'd1 << (ShRad - 1);

	logic signed [64:0] prod;
	logic [63:0] prod_s1, sum;
	logic        deg_s1;
	logic [31:0] phase, pq, res;
	logic [1:0]  quad;

	// angle times turns-per-unit, one multiplier
	assign prod = $signed(angle) * $signed({1'b0, (mode ? DegScale : RadScale)});

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod[63:0];
			deg_s1  <= mode;
		end
	end

	// round to a 32-bit phase, fold to the nearest quadrant
	assign sum   = prod_s1 + (deg_s1 ? HalfDeg : HalfRad);
	assign phase = deg_s1 ? sum[ShDeg+31:ShDeg] : sum[ShRad+31:ShRad];
	assign pq    = phase + 32'h2000_0000;
	assign quad  = pq[31:30];
	assign res   = phase - {quad, 30'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			d_o.x    <= CordicX0;
			d_o.y    <= '0;
			d_o.z    <= {res[31], res};
			d_o.quad <= quad;
		end
	end

endmodule

### src/pose_to_rotation_transform.sv
// Throughput: one item per cycle while no stalled result holds the pipeline; the 30-cell
// CORDIC row and the two multiplier stages each take a new item every cycle.
// The whole pipeline holds while a result waits under out_stall.
// Reset (arst_n low, asynchronous) clears all valid bits; payload is not reset.
module pose_to_rotation_transform #(
	parameter int ANGLE_FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] angle_x,
	input  logic signed [31:0] angle_y,
	input  logic signed [31:0] angle_z,
	input  logic               mode,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] rot_00,
	output logic signed [31:0] rot_01,
	output logic signed [31:0] rot_02,
	output logic signed [31:0] rot_10,
	output logic signed [31:0] rot_11,
	output logic signed [31:0] rot_12,
	output logic signed [31:0] rot_20,
	output logic signed [31:0] rot_21,
	output logic signed [31:0] rot_22,
	output logic signed [31:0] trans_x,
	output logic signed [31:0] trans_y,
	output logic signed [31:0] trans_z
);
	import rtc_pkg::*;

	localparam int NStg = CordicSteps + 7;

	logic            en;
	logic [NStg-1:0] vld_q;
	logic [95:0]     pos_q [NStg];
	cordic_t         cd [3][CordicSteps+1];
	logic signed [31:0] angle [3];

	logic signed [31:0] c_s33 [3], s_s33 [3];
	logic signed [XyW-1:0] cx_r [3], sx_r [3];

	logic signed [63:0] p_s34 [10];
	logic signed [31:0] cz_s34, sz_s34, sy_s34;
	logic signed [31:0] m_s35 [10];
	logic signed [31:0] cz_s35, sz_s35, sy_s35;
	logic signed [63:0] k_s36, l_s36, mm_s36, n_s36;
	logic signed [31:0] v_s36 [8];
	logic signed [31:0] sy_s36;
	logic signed [31:0] rk, rl, rm, rn;

	// global advance: hold everything while the last result is stalled
	assign en        = !(vld_q[NStg-1] && out_stall);
	assign in_stall  = !en;
	assign out_valid = vld_q[NStg-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NStg-2:0], in_valid};
		end
	end

	// translation rides along
	always_ff @(posedge clk) begin
		if (en) begin
			pos_q[0] <= {pos_x, pos_y, pos_z};
			for (int i = 1; i < NStg; i++) pos_q[i] <= pos_q[i-1];
		end
	end
	assign trans_x = pos_q[NStg-1][95:64];
	assign trans_y = pos_q[NStg-1][63:32];
	assign trans_z = pos_q[NStg-1][31:0];

	assign angle[0] = angle_x;
	assign angle[1] = angle_y;
	assign angle[2] = angle_z;

	// phase front end and CORDIC row, one per axis
	for (genvar a = 0; a < 3; a++) begin : g_axis
		rtc_angle_front #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_front (
			.clk   (clk),
			.en    (en),
			.angle (angle[a]),
			.mode  (mode),
			.d_o   (cd[a][0])
		);
		for (genvar k = 0; k < CordicSteps; k++) begin : g_cell
			rtc_cordic_cell #(.STEP(k)) u_cell (
				.clk (clk),
				.en  (en),
				.d   (cd[a][k]),
				.q_o (cd[a][k+1])
			);
		end

		// undo the quadrant fold, round to Q1.30
		always_comb begin
			unique case (cd[a][CordicSteps].quad)
				2'd0: begin
					cx_r[a] = $signed(cd[a][CordicSteps].x);
					sx_r[a] = $signed(cd[a][CordicSteps].y);
				end
				2'd1: begin
					cx_r[a] = -$signed(cd[a][CordicSteps].y);
					sx_r[a] = $signed(cd[a][CordicSteps].x);
				end
				2'd2: begin
					cx_r[a] = -$signed(cd[a][CordicSteps].x);
					sx_r[a] = -$signed(cd[a][CordicSteps].y);
				end
				default: begin
					cx_r[a] = $signed(cd[a][CordicSteps].y);
					sx_r[a] = -$signed(cd[a][CordicSteps].x);
				end
			endcase
		end

		logic signed [XyW-1:0] cr, sr;
		assign cr = (cx_r[a] + 43'sd512) >>> 10;
		assign sr = (sx_r[a] + 43'sd512) >>> 10;

		always_ff @(posedge clk) begin
			if (en) begin
				c_s33[a] <= clamp_q30(cr[33:0]);
				s_s33[a] <= clamp_q30(sr[33:0]);
			end
		end
	end

	// first product layer
	always_ff @(posedge clk) begin
		if (en) begin
			p_s34[0] <= s_s33[1] * s_s33[0];
			p_s34[1] <= s_s33[1] * c_s33[0];
			p_s34[2] <= c_s33[2] * c_s33[1];
			p_s34[3] <= s_s33[2] * c_s33[0];
			p_s34[4] <= s_s33[2] * s_s33[0];
			p_s34[5] <= s_s33[2] * c_s33[1];
			p_s34[6] <= c_s33[2] * c_s33[0];
			p_s34[7] <= c_s33[2] * s_s33[0];
			p_s34[8] <= c_s33[1] * s_s33[0];
			p_s34[9] <= c_s33[1] * c_s33[0];
			cz_s34   <= c_s33[2];
			sz_s34   <= s_s33[2];
			sy_s34   <= s_s33[1];
		end
	end

	// round first products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 10; i++) m_s35[i] <= rnd_q30(p_s34[i]);
			cz_s35 <= cz_s34;
			sz_s35 <= sz_s34;
			sy_s35 <= sy_s34;
		end
	end

	// second product layer for the triple terms
	always_ff @(posedge clk) begin
		if (en) begin
			k_s36  <= cz_s35 * m_s35[0];
			l_s36  <= sz_s35 * m_s35[0];
			mm_s36 <= cz_s35 * m_s35[1];
			n_s36  <= sz_s35 * m_s35[1];
			for (int i = 0; i < 8; i++) v_s36[i] <= m_s35[i+2];
			sy_s36 <= sy_s35;
		end
	end

	assign rk = rnd_q30(k_s36);
	assign rl = rnd_q30(l_s36);
	assign rm = rnd_q30(mm_s36);
	assign rn = rnd_q30(n_s36);

	// combine and saturate into the output register
	always_ff @(posedge clk) begin
		if (en) begin
			rot_00 <= clamp_q30(34'(v_s36[0]));
			rot_01 <= clamp_q30(34'(rk) - 34'(v_s36[1]));
			rot_02 <= clamp_q30(34'(rm) + 34'(v_s36[2]));
			rot_10 <= clamp_q30(34'(v_s36[3]));
			rot_11 <= clamp_q30(34'(rl) + 34'(v_s36[4]));
			rot_12 <= clamp_q30(34'(rn) - 34'(v_s36[5]));
			rot_20 <= clamp_q30(-34'(sy_s36));
			rot_21 <= clamp_q30(34'(v_s36[6]));
			rot_22 <= clamp_q30(34'(v_s36[7]));
		end
	end

endmodule

### src/rtc_checker.sv
module rtc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] rot_00,
	input logic signed [31:0] rot_20,
	input logic signed [31:0] trans_x
);

	// a result under stall stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// stalled result payload holds (rot_00 and trans_x are checked)
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(rot_00) && $stable(trans_x))
		else $error("stalled result changed");

	// input is held back only by a stalled result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// entries rot_00 and rot_20 stay within one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rot_00 <= 32'sd1073741824 && rot_00 >= -32'sd1073741824
			&& rot_20 <= 32'sd1073741824 && rot_20 >= -32'sd1073741824)
		else $error("rotation entry out of range");

endmodule

bind pose_to_rotation_transform rtc_checker u_rtc_checker (.*);
